/* hdl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checks that a condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error(msg);

// checks that a condition in the next cycle follows from a trigger
`define ASSERT_NEXT(label, trig, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/cda_pkg.sv */
package cda_pkg;

	localparam int RESET_YEAR      = 1900;
	localparam int YEAR_CYCLE      = 400;
	localparam int CENTURY         = 100;
	localparam int RESET_YR_MOD    = RESET_YEAR % YEAR_CYCLE;
	localparam int MONTHS_PER_YEAR = 12;
	localparam int QUEUE_DEPTH     = 2;

	localparam logic [8:0] YR_MOD_LAST = 9'(YEAR_CYCLE - 1);

	typedef enum logic [1:0] {
		FS_IDLE,
		FS_REDUCE,
		FS_ISSUE
	} front_state_t;

	typedef enum logic [1:0] {
		BS_IDLE,
		BS_STEP,
		BS_REPORT
	} back_state_t;

	// command handed from the front to the back through the queue
	typedef struct packed {
		logic       is_load;
		logic [4:0] day;
		logic [3:0] month;
		logic [8:0] yr_mod;
	} cmd_t;

	// leap test on the year taken modulo 400
	function automatic logic is_leap(input logic [8:0] yr_mod);
		logic century;
		century = (yr_mod == 9'(CENTURY)) || (yr_mod == 9'(2 * CENTURY)) ||
			(yr_mod == 9'(3 * CENTURY));
		return (yr_mod[1:0] == 2'b00) && !century;
	endfunction

	function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
		logic [4:0] len;
		unique case (month) inside
			4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
			4'd2: len = leap ? 5'd29 : 5'd28;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

/* hdl/calendar_date_advance_top.sv */
// load transaction: the front reduces the year mod 400 (quotient, then remainder) before it queues the command
// advance transaction: the back steps days_to_add days, one day stepped per cycle
// for advances the back day-step loop sets the pace; the front overlaps the next transaction
// one result register decouples the output side, a two-entry queue sits between front and back
// reset: asynchronous, date becomes 1 jan 1900, queue and result register empty
`include "assert_macros.svh"

module calendar_date_advance_top #(
	parameter int YEAR_BITS  = 16,
	parameter int COUNT_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        mode,
	input  logic [5:0]  new_day,
	input  logic [3:0]  new_month,
	input  logic [15:0] new_year,
	input  logic [15:0] days_to_add,
	output logic        empty,
	input  logic        pop,
	output logic [4:0]  out_day,
	output logic [3:0]  out_month,
	output logic [15:0] out_year
);
	import cda_pkg::*;

	localparam int Q_WIDTH = $bits(cmd_t) + YEAR_BITS + COUNT_BITS;

	logic [31:0]           new_year_ext, days_ext, out_year_ext;
	logic                  q_push, q_full, q_pop, q_empty;
	cmd_t                  f_cmd, b_cmd;
	logic [YEAR_BITS-1:0]  f_year, b_year, res_year;
	logic [COUNT_BITS-1:0] f_count, b_count;
	logic [Q_WIDTH-1:0]    q_wdata, q_rdata;
	logic                  res_in_range;

	assign new_year_ext = 32'(new_year);
	assign days_ext     = 32'(days_to_add);

	cda_front #(
		.YEAR_BITS  (YEAR_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.mode        (mode),
		.new_day     (new_day),
		.new_month   (new_month),
		.new_year    (new_year_ext[YEAR_BITS-1:0]),
		.days_to_add (days_ext[COUNT_BITS-1:0]),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_cmd       (f_cmd),
		.q_year      (f_year),
		.q_count     (f_count)
	);

	assign q_wdata = {f_cmd, f_year, f_count};

	cda_fifo #(
		.WIDTH (Q_WIDTH),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.rd     (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	assign {b_cmd, b_year, b_count} = q_rdata;

	cda_back #(
		.YEAR_BITS  (YEAR_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.q_cmd     (b_cmd),
		.q_year    (b_year),
		.q_count   (b_count),
		.empty     (empty),
		.pop       (pop),
		.out_day   (out_day),
		.out_month (out_month),
		.out_year  (res_year)
	);

	assign out_year_ext = 32'(res_year);
	assign out_year     = out_year_ext[15:0];

	assign res_in_range = (out_day != 5'd0) && (out_month != 4'd0) &&
		(out_month <= 4'(MONTHS_PER_YEAR));

	`ASSERT_ALWAYS(a_no_queue_overrun, !(q_push && q_full), "front wrote into a full queue")
	`ASSERT_ALWAYS(a_no_queue_underrun, !(q_pop && q_empty), "back read from an empty queue")
	`ASSERT_NEXT(a_date_in_range, !empty, empty || res_in_range, "result date out of range")

endmodule

/* hdl/cda_front.sv */
module cda_front #(
	parameter int YEAR_BITS  = 16,
	parameter int COUNT_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic                  mode,
	input  logic [5:0]            new_day,
	input  logic [3:0]            new_month,
	input  logic [YEAR_BITS-1:0]  new_year,
	input  logic [COUNT_BITS-1:0] days_to_add,
	input  logic                  q_full,
	output logic                  q_push,
	output cda_pkg::cmd_t         q_cmd,
	output logic [YEAR_BITS-1:0]  q_year,
	output logic [COUNT_BITS-1:0] q_count
);
	import cda_pkg::*;

	// 400 = 16 * 25, so year / 400 is (year >> 4) / 25
	localparam int LOW_BITS    = 4;
	localparam int ODD_DIV     = YEAR_CYCLE >> LOW_BITS;
	localparam int X_W         = YEAR_BITS - LOW_BITS;
	localparam int RECIP_SHIFT = YEAR_BITS + 1;
	localparam int RECIP_W     = YEAR_BITS - 3;
	localparam int PROD_W      = X_W + RECIP_W;
	localparam int QUOT_W      = PROD_W - RECIP_SHIFT;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(ODD_DIV - 1)) / 64'(ODD_DIV));

	front_state_t state_q, state_d;

	logic                  mode_q;
	logic [5:0]            day_q;
	logic [3:0]            month_q;
	logic [YEAR_BITS-1:0]  year_q;
	logic [COUNT_BITS-1:0] count_q;
	logic [8:0]            rem_q;
	logic [QUOT_W-1:0]     quot_q;
	logic                  phase_q;

	logic                 accept;
	logic [PROD_W-1:0]    prod;
	logic [YEAR_BITS-1:0] rem_full;
	logic [8:0]           rem_next;
	logic [3:0]           month_fix;
	logic [4:0]           month_len;
	logic                 day_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		full    = 1'b1;
		q_push  = 1'b0;
		accept  = 1'b0;
		unique case (state_q)
			FS_IDLE: begin
				full = 1'b0;
				if (push) begin
					accept  = 1'b1;
					state_d = mode ? FS_ISSUE : FS_REDUCE;
				end
			end
			FS_REDUCE: begin
				if (phase_q) begin
					state_d = FS_ISSUE;
				end
			end
			FS_ISSUE: begin
				if (!q_full) begin
					q_push  = 1'b1;
					state_d = FS_IDLE;
				end
			end
			default: state_d = FS_IDLE;
		endcase
	end

	// year mod 400: quotient by reciprocal multiply first, remainder the cycle after
	assign prod     = PROD_W'(year_q[YEAR_BITS-1:LOW_BITS]) * PROD_W'(RECIP);
	assign rem_full = year_q - (YEAR_BITS'(quot_q) * YEAR_BITS'(YEAR_CYCLE));
	assign rem_next = rem_full[8:0];

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q  <= mode;
			day_q   <= new_day;
			month_q <= new_month;
			year_q  <= new_year;
			count_q <= days_to_add;
			rem_q   <= '0;
			phase_q <= 1'b0;
		end else if (state_q == FS_REDUCE) begin
			if (!phase_q) begin
				quot_q <= prod[PROD_W-1:RECIP_SHIFT];
			end else begin
				rem_q <= rem_next;
			end
			phase_q <= 1'b1;
		end
	end

	assign month_fix = ((month_q >= 4'd1) && (month_q <= 4'(MONTHS_PER_YEAR))) ?
		month_q : 4'd1;
	assign month_len = month_days(month_fix, is_leap(rem_q));
	assign day_ok    = (day_q != 6'd0) && (day_q <= 6'(month_len));

	assign q_cmd.is_load = !mode_q;
	assign q_cmd.day     = day_ok ? day_q[4:0] : 5'd1;
	assign q_cmd.month   = month_fix;
	assign q_cmd.yr_mod  = rem_q;
	assign q_year        = year_q;
	assign q_count       = count_q;

endmodule

/* hdl/cda_fifo.sv */
module cda_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             rd,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             wr_en, rd_en;

	assign full  = (cnt_q == CNT_W'(DEPTH));
	assign empty = (cnt_q == '0);
	assign wr_en = wr && !full;
	assign rd_en = rd && !empty;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({wr_en, rd_en})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

/* hdl/cda_back.sv */
module cda_back #(
	parameter int YEAR_BITS  = 16,
	parameter int COUNT_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_empty,
	output logic                  q_pop,
	input  cda_pkg::cmd_t         q_cmd,
	input  logic [YEAR_BITS-1:0]  q_year,
	input  logic [COUNT_BITS-1:0] q_count,
	output logic                  empty,
	input  logic                  pop,
	output logic [4:0]            out_day,
	output logic [3:0]            out_month,
	output logic [YEAR_BITS-1:0]  out_year
);
	import cda_pkg::*;

	back_state_t state_q, state_d;

	logic [4:0]            cur_day_q;
	logic [3:0]            cur_month_q;
	logic [YEAR_BITS-1:0]  cur_year_q;
	logic [8:0]            yr_mod_q;
	logic [COUNT_BITS-1:0] remain_q;
	logic                  res_valid_q;

	logic load_en, count_en, step_en, res_wr, slot_free;
	logic [4:0] month_len;
	logic       month_end, year_end;

	assign slot_free = !res_valid_q || pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		q_pop    = 1'b0;
		load_en  = 1'b0;
		count_en = 1'b0;
		step_en  = 1'b0;
		res_wr   = 1'b0;
		unique case (state_q)
			BS_IDLE: begin
				if (!q_empty) begin
					q_pop = 1'b1;
					if (q_cmd.is_load) begin
						load_en = 1'b1;
						state_d = BS_REPORT;
					end else begin
						count_en = 1'b1;
						state_d  = BS_STEP;
					end
				end
			end
			BS_STEP: begin
				if (remain_q == '0) begin
					state_d = BS_REPORT;
				end else begin
					step_en = 1'b1;
				end
			end
			BS_REPORT: begin
				if (slot_free) begin
					res_wr  = 1'b1;
					state_d = BS_IDLE;
				end
			end
			default: state_d = BS_IDLE;
		endcase
	end

	assign month_len = month_days(cur_month_q, is_leap(yr_mod_q));
	assign month_end = (cur_day_q >= month_len);
	assign year_end  = (cur_month_q >= 4'(MONTHS_PER_YEAR));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_day_q   <= 5'd1;
			cur_month_q <= 4'd1;
			cur_year_q  <= YEAR_BITS'(RESET_YEAR);
			yr_mod_q    <= 9'(RESET_YR_MOD);
			res_valid_q <= 1'b0;
		end else begin
			if (load_en) begin
				cur_day_q   <= q_cmd.day;
				cur_month_q <= q_cmd.month;
				cur_year_q  <= q_year;
				yr_mod_q    <= q_cmd.yr_mod;
			end else if (step_en) begin
				if (!month_end) begin
					cur_day_q <= cur_day_q + 1'b1;
				end else begin
					cur_day_q <= 5'd1;
					if (!year_end) begin
						cur_month_q <= cur_month_q + 1'b1;
					end else begin
						cur_month_q <= 4'd1;
						cur_year_q  <= cur_year_q + 1'b1;
						// a wrap to year zero restarts the 400 year cycle too
						if ((&cur_year_q) || (yr_mod_q == YR_MOD_LAST)) begin
							yr_mod_q <= '0;
						end else begin
							yr_mod_q <= yr_mod_q + 1'b1;
						end
					end
				end
			end
			if (res_wr) begin
				res_valid_q <= 1'b1;
			end else if (pop) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (count_en) begin
			remain_q <= q_count;
		end else if (step_en) begin
			remain_q <= remain_q - 1'b1;
		end
		if (res_wr) begin
			out_day   <= cur_day_q;
			out_month <= cur_month_q;
			out_year  <= cur_year_q;
		end
	end

	assign empty = !res_valid_q;

endmodule

/* bench/calendar_date_advance_checker.sv */
`timescale 1ns / 100ps

package cda_tb_pkg;

	typedef enum logic {
		OP_LOAD    = 1'b0,
		OP_ADVANCE = 1'b1
	} date_op_t;

	typedef struct packed {
		logic [4:0]  day;
		logic [3:0]  month;
		logic [15:0] year;
	} date_t;

endpackage

module calendar_date_advance_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic        mode,
	input  logic [5:0]  new_day,
	input  logic [3:0]  new_month,
	input  logic [15:0] new_year,
	input  logic [15:0] days_to_add,
	input  logic        empty,
	input  logic        pop,
	input  logic [4:0]  out_day,
	input  logic [3:0]  out_month,
	input  logic [15:0] out_year,
	output int          mismatches,
	output int          pending
);
	import cda_tb_pkg::*;

	date_t held_date;
	date_t expected_dates[$];
	int errs;

	function automatic logic leap_year(input logic [15:0] y);
		int unsigned v;
		v = y;
		return (v % 400 == 0) || ((v % 100 != 0) && (v % 4 == 0));
	endfunction

	function automatic logic [4:0] month_length(input logic [3:0] m, input logic [15:0] y);
		logic [4:0] len;
		case (m)
			4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
			4'd2: len = leap_year(y) ? 5'd29 : 5'd28;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

	function automatic date_t day_after(input date_t dt);
		date_t nx;
		nx = dt;
		if (dt.day >= month_length(dt.month, dt.year)) begin
			nx.day = 5'd1;
			if (dt.month >= 4'(cda_pkg::MONTHS_PER_YEAR)) begin
				nx.month = 4'd1;
				nx.year = dt.year + 16'd1;
			end else begin
				nx.month = dt.month + 4'd1;
			end
		end else begin
			nx.day = dt.day + 5'd1;
		end
		return nx;
	endfunction

	function automatic date_t date_after_op(input date_t dt, input date_op_t op,
			input logic [5:0] d, input logic [3:0] m, input logic [15:0] y,
			input logic [15:0] n);
		date_t res;
		logic [3:0] mon;
		res = dt;
		if (op == OP_LOAD) begin
			mon = (m < 4'd1 || m > 4'(cda_pkg::MONTHS_PER_YEAR)) ? 4'd1 : m;
			res.month = mon;
			res.year = y;
			// month length is at most 31, so a day that passes fits in five bits
			res.day = (d == 6'd0 || d > 6'(month_length(mon, y))) ? 5'd1 : d[4:0];
		end else begin
			for (int i = 0; i < int'(n); i++)
				res = day_after(res);
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		date_t want;
		if (!arst_n) begin
			held_date = '{day: 5'd1, month: 4'd1, year: 16'(cda_pkg::RESET_YEAR)};
			expected_dates.delete();
			errs = 0;
			mismatches <= 0;
			pending <= 0;
		end else begin
			// result side first: an item accepted now cannot have its result out yet
			if (pop && !empty) begin
				if (expected_dates.size() == 0) begin
					$error("result transaction with nothing expected: %0d/%0d/%0d",
						out_day, out_month, out_year);
					errs++;
				end else begin
					want = expected_dates.pop_front();
					if (out_day !== want.day) begin
						$error("out_day expected %0d actual %0d", want.day, out_day);
						errs++;
					end
					if (out_month !== want.month) begin
						$error("out_month expected %0d actual %0d", want.month, out_month);
						errs++;
					end
					if (out_year !== want.year) begin
						$error("out_year expected %0d actual %0d", want.year, out_year);
						errs++;
					end
				end
			end
			if (push && !full) begin
				held_date = date_after_op(held_date, date_op_t'(mode), new_day, new_month,
					new_year, days_to_add);
				expected_dates.push_back(held_date);
			end
			mismatches <= errs;
			pending <= expected_dates.size();
		end
	end

endmodule

/* bench/calendar_date_advance_top_tb.sv */
`timescale 1ns / 100ps

module calendar_date_advance_top_tb;
	import cda_tb_pkg::*;

	localparam int STALL_LIMIT      = 300000;
	localparam int SETTLE_CYCLES    = 64;
	localparam int RANDOM_PER_PHASE = 470;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        pop = 1'b0;
	logic        mode = 1'b0;
	logic [5:0]  new_day = '0;
	logic [3:0]  new_month = '0;
	logic [15:0] new_year = '0;
	logic [15:0] days_to_add = '0;
	logic        full;
	logic        empty;
	logic [4:0]  out_day;
	logic [3:0]  out_month;
	logic [15:0] out_year;

	int mismatches;
	int pending;
	int send_idle_pct = 0;
	int pop_stall_pct = 0;
	int quiet_cycles = 0;
	int idle_plan[4] = '{0, 61, 0, 25};
	int stall_plan[4] = '{0, 0, 61, 25};

	calendar_date_advance_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.mode(mode),
		.new_day(new_day),
		.new_month(new_month),
		.new_year(new_year),
		.days_to_add(days_to_add),
		.empty(empty),
		.pop(pop),
		.out_day(out_day),
		.out_month(out_month),
		.out_year(out_year)
	);

	calendar_date_advance_checker chk (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.mode(mode),
		.new_day(new_day),
		.new_month(new_month),
		.new_year(new_year),
		.days_to_add(days_to_add),
		.empty(empty),
		.pop(pop),
		.out_day(out_day),
		.out_month(out_month),
		.out_year(out_year),
		.mismatches(mismatches),
		.pending(pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		forever begin
			@(posedge clk);
			pop <= ($urandom_range(99) >= pop_stall_pct);
		end
	end

	// no transaction on either side for too long means the block hung
	initial begin
		forever begin
			@(posedge clk);
			if (!arst_n || (push && !full) || (pop && !empty))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	task automatic send(input date_op_t op, input int d, input int m, input int y,
			input int n);
		if ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		push <= 1'b1;
		mode <= op;
		new_day <= 6'(d);
		new_month <= 4'(m);
		new_year <= 16'(y);
		days_to_add <= 16'(n);
		do @(posedge clk); while (full);
	endtask

	task automatic wait_all_results();
		push <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	function automatic int pick_year();
		int r;
		r = $urandom_range(99);
		if (r < 25)
			return 100 * $urandom_range(0, 655);
		else if (r < 45)
			return 4 * $urandom_range(0, 16383);
		else if (r < 60)
			return $urandom_range(65532, 65535);
		else if (r < 65)
			return $urandom_range(0, 3);
		return $urandom_range(65535);
	endfunction

	task automatic send_random();
		int r;
		int d;
		int m;
		int n;
		r = $urandom_range(99);
		if (r < 40) begin
			if ($urandom_range(9) < 2) begin
				d = $urandom_range(63);
				m = $urandom_range(15);
			end else begin
				m = $urandom_range(1, 12);
				// lean on month ends so rollovers and bad days show up often
				d = $urandom_range(1) ? $urandom_range(26, 31) : $urandom_range(1, 31);
			end
			send(OP_LOAD, d, m, pick_year(), $urandom_range(65535));
		end else begin
			r = $urandom_range(999);
			if (r < 400)
				n = $urandom_range(0, 3);
			else if (r < 860)
				n = $urandom_range(4, 62);
			else if (r < 995)
				n = $urandom_range(63, 800);
			else
				n = $urandom_range(801, 65535);
			send(OP_ADVANCE, $urandom_range(63), $urandom_range(15), $urandom_range(65535), n);
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		send(OP_ADVANCE, 0, 0, 0, 0);
		send(OP_ADVANCE, 63, 15, 65535, 1);
		send(OP_LOAD, 29, 2, 1900, 0);
		send(OP_LOAD, 29, 2, 2000, 65535);
		send(OP_ADVANCE, 0, 0, 0, 1);
		send(OP_LOAD, 29, 2, 2100, 0);
		send(OP_LOAD, 29, 2, 2004, 0);
		send(OP_LOAD, 31, 4, 2023, 0);
		send(OP_LOAD, 30, 6, 2023, 0);
		send(OP_ADVANCE, 0, 0, 0, 1);
		send(OP_LOAD, 0, 0, 0, 0);
		send(OP_LOAD, 63, 15, 65535, 0);
		send(OP_LOAD, 32, 13, 1999, 0);
		send(OP_LOAD, 29, 2, 0, 0);
		// year wraps to zero
		send(OP_LOAD, 31, 12, 65535, 0);
		send(OP_ADVANCE, 0, 0, 0, 1);
		send(OP_LOAD, 28, 2, 1999, 0);
		send(OP_ADVANCE, 0, 0, 0, 1);
		send(OP_LOAD, 31, 1, 2024, 0);
		send(OP_ADVANCE, 0, 0, 0, 29);
		send(OP_ADVANCE, 0, 0, 0, 1);
		send(OP_LOAD, 1, 1, 2000, 0);
		send(OP_ADVANCE, 0, 0, 0, 65535);
		send(OP_ADVANCE, 42, 9, 12345, 366);
		wait_all_results();

		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = idle_plan[ph];
			pop_stall_pct = stall_plan[ph];
			repeat (RANDOM_PER_PHASE) send_random();
			wait_all_results();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+hdl
hdl/cda_pkg.sv
hdl/cda_front.sv
hdl/cda_fifo.sv
hdl/cda_back.sv
hdl/calendar_date_advance_top.sv
bench/calendar_date_advance_checker.sv
bench/calendar_date_advance_top_tb.sv
